FILE: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Constants and helper functions shared by the MD5 byte stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int BlockWords = 16;
    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN
    } core_state_t;

    // Per-round additive constant.
    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    // Rotate amount for a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Message word index used in a round.
    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0: g = r[3:0];
                2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
                2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
                2'd3: g = 4'(r[3:0] * 4'd7);
                default: g = 4'd0;
            endcase
            return g;
        end
    endfunction

endpackage

FILE: sv/md5_core.sv
// ----------------------------------------------------------------------------
// MD5 compression core
// Runs 64 rounds, one per cycle, reading message words from a block memory
// owned by the caller, then adds the working words into the chaining words.
// ----------------------------------------------------------------------------
module md5_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,         // begin a compression from chain_in
    input  logic [127:0] chain_in,      // {d, c, b, a}
    output logic [3:0]   word_addr,     // memory read address, data next cycle
    input  logic [31:0]  word_data,
    output logic         done,          // one cycle pulse, chain_out valid
    output logic [127:0] chain_out
);

    md5_pkg::core_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        rd_ok_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [127:0] base_reg;
    logic [31:0] f, sum, rot;
    logic [4:0]  sh;
    logic [5:0]  fetch_round;

    // Word for round r is read in the cycle before round r executes.
    assign fetch_round = (state_reg == md5_pkg::CORE_RUN) ? 6'(round_reg + 6'd1) : 6'd0;
    assign word_addr = md5_pkg::word_index(fetch_round);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            md5_pkg::CORE_IDLE:
            begin
                if (start)
                begin
                    state_next = md5_pkg::CORE_RUN;
                    round_next = 6'd0;
                end
            end
            md5_pkg::CORE_RUN:
            begin
                round_next = 6'(round_reg + 6'd1);
                if (round_reg == 6'd63)
                    state_next = md5_pkg::CORE_IDLE;
            end
            default: state_next = md5_pkg::CORE_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
            default: f = 32'h0;
        endcase
        sum = f + a_reg + md5_pkg::round_const(round_reg) + word_data;
        sh  = md5_pkg::rot_amount(round_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign done = rd_ok_reg;
    assign chain_out = {base_reg[127:96] + d_reg, base_reg[95:64] + c_reg,
                        base_reg[63:32] + b_reg, base_reg[31:0] + a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::CORE_IDLE;
            round_reg <= 6'd0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            rd_ok_reg <= (state_reg == md5_pkg::CORE_RUN) && (round_reg == 6'd63);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == md5_pkg::CORE_IDLE && start)
        begin
            base_reg <= chain_in;
            a_reg <= chain_in[31:0];
            b_reg <= chain_in[63:32];
            c_reg <= chain_in[95:64];
            d_reg <= chain_in[127:96];
        end
        else if (state_reg == md5_pkg::CORE_RUN)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

endmodule

FILE: sv/md5_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// MD5 byte stream hasher
// Hashes a byte stream with MD5 and emits the digest as two 64-bit items.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one item per cycle, tdata = data_byte, tuser
// = byte_valid, tlast = end_of_message. Items with tuser low carry no byte;
// an item with tlast closes the message (an empty message is allowed).
// Bytes are packed into one of two 16-word block memories (ping-pong). When
// a block fills, the compression core takes it once it is free and runs 64
// rounds, one per cycle, reading one message word a cycle from that memory,
// while new bytes go into the other one. The core holds a buffer from start
// through its rounds to done, and the input stalls while the buffer it
// would fill next is still full. Input also stalls at the end of a message:
// through the padding of one or two blocks and their compressions, plus any
// time an earlier block still spends in the core, until the digest is out.
// The master channel gives bytes 0-7 of the digest with tlast low, then
// bytes 8-15 with tlast high. A stall on the master side holds the digest
// and holds off the next message. After reset, and after each digest, the
// chaining words, the byte count and the buffers start over; the buffers
// are cleared by the padding writes rather than by a sweep.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // byte_valid
    input  logic        s_tlast,    // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] digest_half
    output logic        m_tlast     // digest_last
);

    // Block memories; byte lanes written individually.
    logic [31:0] mem0 [md5_pkg::BlockWords];
    logic [31:0] mem1 [md5_pkg::BlockWords];

    logic [60:0]  count_reg;
    logic         wbuf_reg;      // buffer taking bytes
    logic [1:0]   full_reg;      // buffer waiting for or held by the core
    logic         cbuf_reg;      // buffer the core reads
    logic         busy_reg;
    logic [127:0] chain_reg;
    // Padding sequencer.
    logic         pad_reg;       // padding a message end
    logic [3:0]   pw_reg;        // word being padded
    logic         twice_reg;     // length goes in a second block
    logic         final_reg;     // last compression runs
    logic         out_reg;
    logic         half_reg;

    logic         acc, byte_in, start;
    logic [3:0]   raddr;
    logic [31:0]  rd0_reg, rd1_reg, rdata;
    logic         done;
    logic [127:0] chain_out;
    logic [5:0]   pos;
    logic [63:0]  bits;
    logic [31:0]  pad_word;
    logic         pad_wr, pad_block_done;
    logic         len_blk;

    assign pos  = count_reg[5:0];
    assign bits = {count_reg, 3'b000};

    assign s_tready = !pad_reg && !final_reg && !out_reg && !full_reg[wbuf_reg];
    assign acc = s_tvalid && s_tready;
    assign byte_in = acc && s_tuser;

    // The block being padded takes the length unless the marker lands at
    // byte 56 or later, in which case the second block takes it.
    assign len_blk = twice_reg || (pos < 6'd56);

    // Padding word: 0x80 marker at the byte after the count, zeros after,
    // length in words 14 and 15 of the closing block.
    always_comb
    begin
        pad_word = 32'h0;
        if (len_blk && pw_reg == 4'd14)
            pad_word = bits[31:0];
        else if (len_blk && pw_reg == 4'd15)
            pad_word = bits[63:32];
        else if (!twice_reg && pw_reg == pos[5:2])
            pad_word = 32'h80 << {pos[1:0], 3'b000};
    end

    // Padding writes whole words at or above the marker word; the marker word
    // keeps its existing low bytes.
    assign pad_wr = pad_reg && !full_reg[wbuf_reg] && (pw_reg >= pos[5:2] || twice_reg);
    assign pad_block_done = pad_reg && !full_reg[wbuf_reg] && pw_reg == 4'd15;

    always_ff @(posedge clk)
    begin
        if (byte_in && !wbuf_reg)
        begin
            unique case (pos[1:0])
                2'd0: mem0[pos[5:2]][7:0]   <= s_tdata;
                2'd1: mem0[pos[5:2]][15:8]  <= s_tdata;
                2'd2: mem0[pos[5:2]][23:16] <= s_tdata;
                2'd3: mem0[pos[5:2]][31:24] <= s_tdata;
                default: ;
            endcase
        end
        else if (pad_wr && !wbuf_reg)
        begin
            if (pw_reg == pos[5:2] && !twice_reg)
            begin
                unique case (pos[1:0])
                    2'd0: mem0[pw_reg] <= pad_word;
                    2'd1: mem0[pw_reg][31:8] <= pad_word[31:8];
                    2'd2: mem0[pw_reg][31:16] <= pad_word[31:16];
                    2'd3: mem0[pw_reg][31:24] <= pad_word[31:24];
                    default: ;
                endcase
            end
            else
                mem0[pw_reg] <= pad_word;
        end
        rd0_reg <= mem0[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (byte_in && wbuf_reg)
        begin
            unique case (pos[1:0])
                2'd0: mem1[pos[5:2]][7:0]   <= s_tdata;
                2'd1: mem1[pos[5:2]][15:8]  <= s_tdata;
                2'd2: mem1[pos[5:2]][23:16] <= s_tdata;
                2'd3: mem1[pos[5:2]][31:24] <= s_tdata;
                default: ;
            endcase
        end
        else if (pad_wr && wbuf_reg)
        begin
            if (pw_reg == pos[5:2] && !twice_reg)
            begin
                unique case (pos[1:0])
                    2'd0: mem1[pw_reg] <= pad_word;
                    2'd1: mem1[pw_reg][31:8] <= pad_word[31:8];
                    2'd2: mem1[pw_reg][31:16] <= pad_word[31:16];
                    2'd3: mem1[pw_reg][31:24] <= pad_word[31:24];
                    default: ;
                endcase
            end
            else
                mem1[pw_reg] <= pad_word;
        end
        rd1_reg <= mem1[raddr];
    end

    assign rdata = cbuf_reg ? rd1_reg : rd0_reg;

    // Start the core on the oldest full buffer once it is free.
    logic next_cbuf;
    assign next_cbuf = full_reg[cbuf_reg] ? cbuf_reg : !cbuf_reg;
    assign start = !busy_reg && (full_reg != 2'b00);

    md5_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .chain_in  (chain_reg),
        .word_addr (raddr),
        .word_data (rdata),
        .done      (done),
        .chain_out (chain_out)
    );

    logic [1:0] full_next;
    logic       block_full;
    assign block_full = byte_in && pos == 6'd63;

    always_comb
    begin
        full_next = full_reg;
        if (done)
            full_next[cbuf_reg] = 1'b0;
        if (block_full || pad_block_done)
            full_next[wbuf_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wbuf_reg  <= 1'b0;
            full_reg  <= 2'b00;
            cbuf_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            chain_reg <= {md5_pkg::InitD, md5_pkg::InitC, md5_pkg::InitB, md5_pkg::InitA};
            pad_reg   <= 1'b0;
            pw_reg    <= 4'd0;
            twice_reg <= 1'b0;
            final_reg <= 1'b0;
            out_reg   <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            if (start)
            begin
                busy_reg <= 1'b1;
                cbuf_reg <= next_cbuf;
            end
            else if (done)
                busy_reg <= 1'b0;
            if (done)
                chain_reg <= chain_out;

            if (byte_in)
            begin
                count_reg <= count_reg + 61'd1;
                if (pos == 6'd63)
                    wbuf_reg <= !wbuf_reg;
            end
            if (acc && s_tlast)
            begin
                pad_reg   <= 1'b1;
                pw_reg    <= 4'd0;
                twice_reg <= 1'b0;
            end
            if (pad_reg && !full_reg[wbuf_reg])
            begin
                pw_reg <= pw_reg + 4'd1;
                if (pw_reg == 4'd15)
                begin
                    wbuf_reg <= !wbuf_reg;
                    // Marker at byte 56 or later: length needs one more block.
                    if (!twice_reg && pos >= 6'd56)
                        twice_reg <= 1'b1;
                    else
                    begin
                        pad_reg   <= 1'b0;
                        final_reg <= 1'b1;
                    end
                end
            end
            if (final_reg && !busy_reg && full_reg == 2'b00 && !start)
            begin
                final_reg <= 1'b0;
                out_reg   <= 1'b1;
                half_reg  <= 1'b0;
            end
            if (out_reg && m_tready)
            begin
                if (half_reg)
                begin
                    out_reg   <= 1'b0;
                    count_reg <= '0;
                    chain_reg <= {md5_pkg::InitD, md5_pkg::InitC,
                                  md5_pkg::InitB, md5_pkg::InitA};
                end
                half_reg <= !half_reg;
            end
        end
    end

    assign m_tvalid = out_reg;
    assign m_tlast  = half_reg;
    assign m_tdata  = half_reg ? chain_reg[127:64] : chain_reg[63:0];

endmodule

FILE: tb/sv/md5_digest_checker.sv
// ----------------------------------------------------------------------------
// MD5 digest checker
// Watches both streams of the hasher, computes the expected digest halves
// and compares each accepted output item against the oldest expected one.
// ----------------------------------------------------------------------------
module md5_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [63:0] half;
        logic        last;
    } digest_half_t;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                   6, 10, 15, 21};

    logic [31:0]  hash_a, hash_b, hash_c, hash_d;
    logic [31:0]  msg_words [16];
    logic [60:0]  msg_bytes;
    digest_half_t expected_halves [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // One 64-round MD5 compression of msg_words into the chaining words.
    function void md5_compress();
        logic [31:0] a, b, c, d, f;
        int          g;
        a = hash_a; b = hash_b; c = hash_c; d = hash_d;
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            f = f + a + SINE_K[r] + msg_words[g];
            a = d;
            d = c;
            c = b;
            b = b + rotl(f, SHIFTS[(r / 16) * 4 + r % 4]);
        end
        hash_a += a; hash_b += b; hash_c += c; hash_d += d;
    endfunction

    function void store_byte(input int pos, input logic [7:0] v);
        msg_words[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function void restart();
        hash_a = md5_pkg::InitA;
        hash_b = md5_pkg::InitB;
        hash_c = md5_pkg::InitC;
        hash_d = md5_pkg::InitD;
        for (int i = 0; i < 16; i++)
            msg_words[i] = '0;
        msg_bytes = '0;
    endfunction

    // Applies one accepted input item; on end of message it queues both halves.
    function void absorb_item(input logic [7:0] data, input logic valid, input logic eom);
        logic [63:0] bit_len;
        int          pos;
        if (valid)
        begin
            store_byte(int'(msg_bytes[5:0]), data);
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0)
                md5_compress();
        end
        if (eom)
        begin
            bit_len = {msg_bytes, 3'b000};
            pos = int'(msg_bytes[5:0]);
            store_byte(pos, 8'h80);
            for (int i = pos + 1; i < 64; i++)
                store_byte(i, 8'h00);
            // No room left for the length: an extra block is needed.
            if (pos >= 56)
            begin
                md5_compress();
                for (int i = 0; i < 16; i++)
                    msg_words[i] = '0;
            end
            msg_words[14] = bit_len[31:0];
            msg_words[15] = bit_len[63:32];
            md5_compress();
            expected_halves.push_back('{half: {hash_b, hash_a}, last: 1'b0});
            expected_halves.push_back('{half: {hash_d, hash_c}, last: 1'b1});
            restart();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_half_t exp_h;
        int           n_err;
        n_err = 0;
        if (!rst_n)
        begin
            restart();
            expected_halves.delete();
            errors  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_halves.size() == 0)
                begin
                    $error("digest item with none expected: tdata=%h tlast=%b",
                           m_tdata, m_tlast);
                    n_err++;
                end
                else
                begin
                    exp_h = expected_halves.pop_front();
                    if (m_tdata !== exp_h.half)
                    begin
                        $error("digest_half: expected %h, actual %h", exp_h.half, m_tdata);
                        n_err++;
                    end
                    if (m_tlast !== exp_h.last)
                    begin
                        $error("digest_last: expected %b, actual %b", exp_h.last, m_tlast);
                        n_err++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_item(s_tdata, s_tuser, s_tlast);
            errors <= errors + n_err;
        end
        pending <= expected_halves.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// MD5 byte stream hasher testbench
// Feeds byte messages of many lengths under random flow control and lets the
// digest checker compare every digest half against its own MD5 computation.
// ----------------------------------------------------------------------------
module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;

    // Idle percentages of both sides; changed by the stimulus between phases.
    int          tx_idle_pct;
    int          rx_idle_pct;
    // A request for one long stall of the receiver, served by its own process.
    bit          long_stall_req;
    int          stall_left;
    int          items_sent;
    longint      cycles;

    md5_byte_stream_hasher i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    md5_digest_checker i_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog. The slowest correct run is far below this limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so
    // that the hasher fills up and stalls its input side.
    always @(negedge clk)
    begin
        if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            stall_left = 600;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offers one item and holds it until the hasher takes it. Random idle
    // cycles go before the item; inputs change only at the falling edge.
    task automatic offer_item(input logic [7:0] data, input logic valid, input logic eom);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        if (valid || eom)
            items_sent++;
        @(negedge clk);
    endtask

    // Sends a whole message of len bytes. Idle items are sprinkled in, and
    // the closing item either carries the final byte or carries none.
    task automatic send_message(input int len);
        bit byte_on_eom;
        int n;
        byte_on_eom = (len > 0) && $urandom_range(1);
        n = byte_on_eom ? len - 1 : len;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                offer_item(8'($urandom), 1'b0, 1'b0);
            offer_item(8'($urandom), 1'b1, 1'b0);
        end
        offer_item(8'($urandom), byte_on_eom, 1'b1);
    endtask

    // Lengths lean toward short messages and toward the padding boundaries.
    function automatic int pick_length();
        int sel;
        int edges [8] = '{0, 55, 56, 57, 63, 64, 119, 120};
        sel = $urandom_range(9);
        if (sel < 3)
            return edges[$urandom_range(7)];
        else if (sel < 9)
            return $urandom_range(40);
        else
            return $urandom_range(200);
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        tx_idle_pct    = 14;
        rx_idle_pct    = 86;
        long_stall_req = 1'b0;
        stall_left     = 0;
        items_sent     = 0;
        cycles         = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, then "abc" with idle items in between,
        // then one-byte messages with the extreme byte values, the byte
        // riding on the closing item or coming before it.
        offer_item(8'hff, 1'b0, 1'b1);
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'hff, 1'b0, 1'b0);
        offer_item(8'h63, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b1);
        offer_item(8'hff, 1'b1, 1'b1);
        offer_item(8'h00, 1'b1, 1'b1);
        offer_item(8'h00, 1'b1, 1'b0);
        offer_item(8'hff, 1'b0, 1'b1);

        // Random messages through three flow-control phases.
        while (items_sent < 600)
        begin
            if (items_sent >= 200 && tx_idle_pct == 14)
            begin
                tx_idle_pct    = 86;
                rx_idle_pct    = 14;
                long_stall_req = 1'b1;
            end
            else if (items_sent >= 400 && tx_idle_pct == 86)
            begin
                // Let the hasher drain completely before the fast phase.
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                long_stall_req = 1'b1;
            end
            send_message(pick_length());
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
